// ----- rtl/bls_pkg.sv -----
package bls_pkg;

    // Store geometry.
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;
    localparam int unsigned CHANNELS   = 3;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned ADDR_W     = 18;
    localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT * CHANNELS;

    // Arithmetic widths.
    localparam int unsigned D_W    = 12;  // node distance terms
    localparam int unsigned M_W    = 24;  // products of two terms
    localparam int unsigned W_W    = 30;  // node weights
    localparam int unsigned P_W    = 39;  // weight times pixel
    localparam int unsigned R_W    = 41;  // row sum
    localparam int unsigned RL_W   = 20;  // low part of a row sum
    localparam int unsigned C_W    = 51;  // partial column product
    localparam int unsigned A_W    = 72;  // column accumulator
    localparam int unsigned SHIFT  = 6 * FRAC_BITS;
    localparam int unsigned LIMIT  = 36 * 256;
    localparam int unsigned RECIP9 = 7282; // ceil(2^16 / 9)

    // Function codes and register indexes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WGTA   = 7'b0000010,
        ST_WGTB   = 7'b0000100,
        ST_RUN    = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_FIN    = 7'b0100000,
        ST_RESULT = 7'b1000000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       mem_wr;
        logic       load;
        logic       wgt_a;
        logic       wgt_b;
        logic       issue;
        logic [3:0] cnt;
        logic       fin;
        logic       out_load;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad_ch;
    } t_status;

endpackage

// ----- rtl/bls_ctrl.sv -----
module bls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_func,
    output logic             o_valid,
    input  logic             i_ready,
    input  bls_pkg::t_status i_status,
    output bls_pkg::t_cmd    o_cmd
);
    import bls_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_valid, n_valid;
    logic       acc_in;
    logic       out_free;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_valid;
    assign acc_in   = i_valid && o_ready;
    assign out_free = !r_valid || i_ready;

    // Next state, counter and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    if (i_func == FUNC_WRITE) begin
                        o_cmd.mem_wr = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = i_status.bad_ch ? ST_RESULT : ST_WGTA;
                    end
                end
            end
            ST_WGTA: begin
                o_cmd.wgt_a = 1'b1;
                n_state = ST_WGTB;
            end
            ST_WGTB: begin
                o_cmd.wgt_b = 1'b1;
                n_cnt = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_cnt = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd3) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

// ----- rtl/bls_dp.sv -----
module bls_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    input  logic [7:0]          i_pixel_x,
    input  logic [7:0]          i_pixel_y,
    input  logic [1:0]          i_channel_sel,
    input  logic [7:0]          i_pixel_value,
    input  logic signed [16:0]  i_sample_x,
    input  logic signed [16:0]  i_sample_y,
    input  bls_pkg::t_cmd       i_cmd,
    output bls_pkg::t_status    o_status,
    output logic [7:0]          o_sample_value
);
    import bls_pkg::*;

    logic [7:0] mem [DEPTH];

    logic [8:0]  r_width, r_height;
    logic signed [8:0] r_fx, r_fy;
    logic [FRAC_BITS-1:0] r_frac [2];
    logic [1:0]  r_ch;
    logic        r_bad;
    logic signed [M_W-1:0] r_m12 [2];
    logic signed [M_W-1:0] r_m03 [2];
    logic signed [M_W-1:0] r_m01 [2];
    logic signed [W_W-1:0] r_wx [4];
    logic signed [W_W-1:0] r_wy [4];
    logic [7:0]  r_rd;
    logic        r_t1_v, r_t1_inb;
    logic [1:0]  r_t1_k, r_t1_j;
    logic signed [P_W-1:0] r_prod;
    logic        r_t2_v;
    logic [1:0]  r_t2_k, r_t2_j;
    logic signed [R_W-1:0] r_row;
    logic        r_t3_v;
    logic [1:0]  r_t3_j;
    logic signed [C_W-1:0] r_pl, r_ph;
    logic        r_t4_v;
    logic signed [A_W-1:0] r_acc;
    logic [11:0] r_y;
    logic        r_sat, r_zero;
    logic [7:0]  r_out;

    logic signed [9:0] nx, ny;
    logic [8:0]  wl, hl;
    logic        inb;
    logic [ADDR_W-1:0] rd_addr, wr_addr, base_rd, base_wr;
    logic signed [D_W-1:0] d0 [2];
    logic signed [D_W-1:0] d1 [2];
    logic signed [D_W-1:0] d2 [2];
    logic signed [D_W-1:0] d3 [2];
    logic signed [W_W-1:0] wgt [2][4];
    logic [7:0]  pix;
    logic signed [R_W-1:0] row_sum;
    logic signed [A_W-1:0] col_term;
    logic [A_W-1:0] rounded;
    logic [24:0] quot;

    assign o_status.bad_ch = (32'(i_channel_sel) >= CHANNELS);
    assign o_sample_value  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Neighbour position and bounds for the current read.
    always_comb begin
        wl = (r_width > 9'd256) ? 9'd256 : r_width;
        hl = (r_height > 9'd256) ? 9'd256 : r_height;
        nx = 10'(r_fx) + $signed({8'd0, i_cmd.cnt[1:0]}) - 10'sd1;
        ny = 10'(r_fy) + $signed({8'd0, i_cmd.cnt[3:2]}) - 10'sd1;
        inb = !nx[9] && !ny[9] && (nx[8:0] < wl) && (ny[8:0] < hl);
        base_rd = {ny[7:0], nx[7:0], 2'b00} - {2'b00, ny[7:0], nx[7:0]};
        base_wr = {i_pixel_y, i_pixel_x, 2'b00} - {2'b00, i_pixel_y, i_pixel_x};
        rd_addr = base_rd + ADDR_W'(r_ch);
        wr_addr = base_wr + ADDR_W'(i_channel_sel);
    end

    // Image memory, single port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && !o_status.bad_ch) begin
            mem[wr_addr] <= i_pixel_value;
        end else if (i_cmd.issue) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Node distance terms and weights for both axes.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            d1[a] = $signed({4'd0, r_frac[a]});
            d0[a] = d1[a] + 12'sd256;
            d2[a] = d1[a] - 12'sd256;
            d3[a] = d1[a] - 12'sd512;
            wgt[a][0] = W_W'(-(r_m12[a] * d3[a]));
            wgt[a][1] = W_W'(3 * (r_m03[a] * d2[a]));
            wgt[a][2] = W_W'(-3 * (r_m03[a] * d1[a]));
            wgt[a][3] = W_W'(r_m01[a] * d2[a]);
        end
    end

    // Query capture and weight setup.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fx      <= i_sample_x[16:8];
            r_fy      <= i_sample_y[16:8];
            r_frac[0] <= i_sample_x[7:0];
            r_frac[1] <= i_sample_y[7:0];
            r_ch      <= i_channel_sel;
            r_bad     <= o_status.bad_ch;
        end
        if (i_cmd.wgt_a) begin
            for (int a = 0; a < 2; a++) begin
                r_m12[a] <= M_W'(d1[a] * d2[a]);
                r_m03[a] <= M_W'(d0[a] * d3[a]);
                r_m01[a] <= M_W'(d0[a] * d1[a]);
            end
        end
        if (i_cmd.wgt_b) begin
            for (int k = 0; k < 4; k++) begin
                r_wx[k] <= wgt[0][k];
                r_wy[k] <= wgt[1][k];
            end
        end
    end

    // Accumulation pipeline: read, weight, row sum, column product, total.
    always_comb begin
        pix      = r_t1_inb ? r_rd : 8'd0;
        row_sum  = (r_t2_k == 2'd0) ? R_W'(r_prod) : r_row + R_W'(r_prod);
        col_term = (A_W'(r_ph) <<< RL_W) + A_W'(r_pl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else begin
            r_t1_v <= i_cmd.issue;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v && (r_t2_k == 2'd3);
            r_t4_v <= r_t3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1_inb <= inb;
        r_t1_k   <= i_cmd.cnt[1:0];
        r_t1_j   <= i_cmd.cnt[3:2];
        r_prod   <= P_W'(r_wx[r_t1_k] * $signed({1'b0, pix}));
        r_t2_k   <= r_t1_k;
        r_t2_j   <= r_t1_j;
        if (r_t2_v) begin
            r_row <= row_sum;
        end
        r_t3_j <= r_t2_j;
        r_pl   <= C_W'(r_wy[r_t3_j] * $signed({1'b0, r_row[RL_W-1:0]}));
        r_ph   <= C_W'(r_wy[r_t3_j] * $signed(r_row[R_W-1:RL_W]));
        if (i_cmd.wgt_a) begin
            r_acc <= '0;
        end else if (r_t4_v) begin
            r_acc <= r_acc + col_term;
        end
    end

    // Rounding, range check and divide by 36: registered first at fin, then at output load.
    always_comb begin
        rounded = (r_acc + (A_W'(18) << SHIFT)) >> SHIFT;
        quot    = 25'(r_y) * 25'(RECIP9);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_zero <= r_acc[A_W-1];
            r_sat  <= (rounded >= A_W'(LIMIT));
            r_y    <= rounded[13:2];
        end
        if (i_cmd.out_load) begin
            priority if (r_bad || r_zero) begin
                r_out <= 8'd0;
            end else if (r_sat) begin
                r_out <= 8'd255;
            end else begin
                r_out <= quot[23:16];
            end
        end
    end

endmodule

// ----- rtl/bicubic_lagrange_sampler.sv -----
// Channel   Handshake                   Payload
// input     i_valid / o_ready           i_func, i_pixel_x, i_pixel_y, i_channel_sel,
//                                       i_pixel_value, i_sample_x, i_sample_y
// result    o_valid / i_ready           o_sample_value
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A pixel write gives no result.
// A query passes through weight setup (ST_WGTA, ST_WGTB), sixteen
// neighbour reads from the single-port image memory, pipeline drain (ST_DRAIN), rounding
// (ST_FIN) and the output load, which waits for a free output register, then raises o_valid.
// A query on an invalid channel goes straight to the output load and raises o_valid with 0.
// Reset restores the image size registers to 256; the image memory is not cleared.
// A stalled result holds in the output register; the next item waits only for its own result.
module bicubic_lagrange_sampler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic [1:0]         i_channel_sel,
    input  logic [7:0]         i_pixel_value,
    input  logic signed [16:0] i_sample_x,
    input  logic signed [16:0] i_sample_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_sample_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data
);
    import bls_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    bls_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_func   (i_func),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bls_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_channel_sel  (i_channel_sel),
        .i_pixel_value  (i_pixel_value),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_sample_value (o_sample_value)
    );

endmodule

// ----- tb/bicubic_lagrange_sampler_tb.sv -----
`timescale 1ns / 100ps

module bicubic_lagrange_sampler_tb;
    import bls_pkg::*;

    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
    localparam int unsigned ONE         = 1 << FRAC_BITS;

    // Mirror of the sampler: image contents, size registers and pending results.
    class sample_scoreboard;
        byte unsigned pixels [STORE_DEPTH];
        bit           filled [STORE_DEPTH];
        int unsigned  cols_reg;
        int unsigned  rows_reg;
        byte unsigned pending_samples[$];

        function new();
            cols_reg = 256;
            rows_reg = 256;
        endfunction

        function int unsigned cols_used();
            return (cols_reg < MAX_WIDTH) ? cols_reg : MAX_WIDTH;
        endfunction

        function int unsigned rows_used();
            return (rows_reg < MAX_HEIGHT) ? rows_reg : MAX_HEIGHT;
        endfunction

        function int unsigned entry(int x, int y, int ch);
            return (y * MAX_WIDTH + x) * CHANNELS + ch;
        endfunction

        function bit in_frame(int x, int y);
            return x >= 0 && y >= 0 && x < int'(cols_used()) && y < int'(rows_used());
        endfunction

        function longint neighbour(int x, int y, int ch);
            if (!in_frame(x, y)) begin
                return 0;
            end
            return pixels[entry(x, y, ch)];
        endfunction

        // Lagrange node weights, scaled by 6 * ONE^3.
        function void lagrange_weights(longint f, output longint w[4]);
            longint t;
            t = ONE + f;
            w[0] = -((t - ONE) * (t - 2 * ONE) * (t - 3 * ONE));
            w[1] = 3 * t * (t - 2 * ONE) * (t - 3 * ONE);
            w[2] = -3 * t * (t - ONE) * (t - 3 * ONE);
            w[3] = t * (t - ONE) * (t - 2 * ONE);
        endfunction

        function byte unsigned bicubic(logic signed [16:0] sx, logic signed [16:0] sy, int ch);
            int                 bx, by;
            longint             wx[4], wy[4], row;
            logic signed [127:0] acc, a, b;
            logic [127:0]       q;
            bx = int'(sx >>> FRAC_BITS);
            by = int'(sy >>> FRAC_BITS);
            lagrange_weights(longint'(sx[FRAC_BITS-1:0]), wx);
            lagrange_weights(longint'(sy[FRAC_BITS-1:0]), wy);
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                row = 0;
                for (int k = 0; k < 4; k++) begin
                    row += wx[k] * neighbour(bx + k - 1, by + j - 1, ch);
                end
                a = wy[j];
                b = row;
                acc += a * b;
            end
            if (acc[127]) begin
                return 0;
            end
            q = (acc + (128'd18 << SHIFT)) >> SHIFT;
            if (q >= LIMIT) begin
                return 255;
            end
            return byte'(q / 36);
        endfunction

        function void set_reg(logic idx, logic [8:0] data);
            if (idx == REG_WIDTH) begin
                cols_reg = data;
            end else begin
                rows_reg = data;
            end
        endfunction

        // Called for every input transfer.
        function void note_input(logic func, logic [7:0] px, logic [7:0] py, logic [1:0] ch,
                                 logic [7:0] val, logic signed [16:0] sx,
                                 logic signed [16:0] sy);
            if (func == FUNC_WRITE) begin
                if (ch < CHANNELS) begin
                    pixels[entry(px, py, ch)] = val;
                    filled[entry(px, py, ch)] = 1'b1;
                end
            end else if (ch >= CHANNELS) begin
                pending_samples.push_back(0);
            end else begin
                pending_samples.push_back(bicubic(sx, sy, ch));
            end
        endfunction

        // Returns 1 on a mismatch or an unexpected result.
        function bit check_result(logic [7:0] got, output string msg);
            byte unsigned want;
            if (pending_samples.size() == 0) begin
                msg = $sformatf("unexpected result %0d", got);
                return 1;
            end
            want = pending_samples.pop_front();
            if (got !== want) begin
                msg = $sformatf("sample_value got %0d expected %0d", got, want);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_func;
    logic [7:0]         i_pixel_x;
    logic [7:0]         i_pixel_y;
    logic [1:0]         i_channel_sel;
    logic [7:0]         i_pixel_value;
    logic signed [16:0] i_sample_x;
    logic signed [16:0] i_sample_y;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_sample_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [8:0]         i_cfg_data;

    sample_scoreboard sb;
    int               mismatches;
    int               items_sent;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_off_cycles;

    bicubic_lagrange_sampler i_dut (.*);

    // Clock, period 8 ns.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Result side: check each transfer, then choose ready for the next cycle.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && i_ready) begin
            if (sb.check_result(o_sample_value, msg)) begin
                report(msg);
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic func, logic [7:0] px, logic [7:0] py, logic [1:0] ch,
                             logic [7:0] val, logic signed [16:0] sx,
                             logic signed [16:0] sy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_pixel_x     <= px;
        i_pixel_y     <= py;
        i_channel_sel <= ch;
        i_pixel_value <= val;
        i_sample_x    <= sx;
        i_sample_y    <= sy;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(func, px, py, ch, val, sx, sy);
        items_sent++;
    endtask

    task automatic write_pixel(int x, int y, int ch, int val);
        send_item(FUNC_WRITE, 8'(x), 8'(y), 2'(ch), 8'(val), 17'($urandom), 17'($urandom));
    endtask

    // Fills every unwritten in-frame neighbour before a query on a valid channel, then sends it.
    task automatic query(logic signed [16:0] sx, logic signed [16:0] sy, logic [1:0] ch);
        int bx, by, x, y;
        bx = int'(sx >>> FRAC_BITS);
        by = int'(sy >>> FRAC_BITS);
        if (ch < CHANNELS) begin
            for (int j = -1; j <= 2; j++) begin
                for (int k = -1; k <= 2; k++) begin
                    x = bx + k;
                    y = by + j;
                    if (sb.in_frame(x, y) && !sb.filled[sb.entry(x, y, ch)]) begin
                        write_pixel(x, y, ch, $urandom_range(255));
                    end
                end
            end
        end
        send_item(FUNC_QUERY, 8'($urandom), 8'($urandom), ch, 8'($urandom), sx, sy);
    endtask

    // Register writes happen only with the sampler drained.
    task automatic write_reg(logic idx, logic [8:0] data);
        i_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic random_query();
        int                 r, x, y;
        logic signed [16:0] sx, sy;
        r = $urandom_range(99);
        if (r < 70) begin
            x  = $urandom_range(sb.cols_used() + 5) - 3;
            y  = $urandom_range(sb.rows_used() + 5) - 3;
            sx = 17'(x * ONE + $urandom_range(ONE - 1));
            sy = 17'(y * ONE + $urandom_range(ONE - 1));
        end else begin
            sx = 17'($urandom);
            sy = 17'($urandom);
        end
        query(sx, sy, ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(CHANNELS - 1)));
    endtask

    initial begin
        int          setting;
        logic [8:0]  cols_seq[8] = '{256, 5, 1, 0, 511, 17, 256, 300};
        logic [8:0]  rows_seq[8] = '{256, 7, 1, 256, 300, 4, 1, 256};

        sb              = new();
        mismatches      = 0;
        items_sent      = 0;
        send_idle_pct   = 37;
        recv_idle_pct   = 83;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_func          = FUNC_WRITE;
        i_pixel_x       = '0;
        i_pixel_y       = '0;
        i_channel_sel   = '0;
        i_pixel_value   = '0;
        i_sample_x      = '0;
        i_sample_y      = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_WIDTH;
        i_cfg_data      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Overshoot patch: bright 2x2 centre ringed by zeros clamps high.
        for (int y = 10; y < 14; y++) begin
            for (int x = 10; x < 14; x++) begin
                write_pixel(x, y, 0, (x inside {[11:12]} && y inside {[11:12]}) ? 255 : 0);
            end
        end
        query(17'(11 * ONE + ONE / 2), 17'(11 * ONE + ONE / 2), 2'd0);
        // Dark centre ringed by bright pixels goes negative and clamps to zero.
        for (int y = 11; y < 13; y++) begin
            for (int x = 11; x < 13; x++) begin
                write_pixel(x, y, 0, 0);
            end
        end
        for (int y = 10; y < 14; y++) begin
            for (int x = 10; x < 14; x++) begin
                if (!(x inside {[11:12]} && y inside {[11:12]})) begin
                    write_pixel(x, y, 0, 255);
                end
            end
        end
        query(17'(11 * ONE + ONE / 2), 17'(11 * ONE + ONE / 2), 2'd0);
        // Integer point, corners, coordinate extremes and the unused channel.
        query(17'(11 * ONE), 17'(11 * ONE), 2'd0);
        query(17'h10000, 17'h10000, 2'd0);
        query(17'h0FFFF, 17'h0FFFF, 2'd2);
        query(17'h00000, 17'h00000, 2'd1);
        query(17'h1FF80, 17'h00080, 2'd1);
        write_pixel(255, 255, 3, 255);
        query(17'(255 * ONE), 17'(255 * ONE), 2'd3);
        query(17'h0FFFF, 17'h10000, 2'd2);

        // Random phases over several frame sizes, both idling patterns and a phase without idling.
        for (setting = 0; setting < 8; setting++) begin
            if (setting == 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 37;
            end else if (setting == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_WIDTH, cols_seq[setting]);
            write_reg(REG_HEIGHT, rows_seq[setting]);
            while (items_sent < 50 + (setting + 1) * 75) begin
                if (setting == 6 && hold_off_cycles == 0 && items_sent % 20 == 0) begin
                    hold_off_cycles = 300;
                end
                if ($urandom_range(99) < 15) begin
                    send_item(FUNC_WRITE, 8'($urandom), 8'($urandom), 2'($urandom),
                              8'($urandom), 17'($urandom), 17'($urandom));
                end else begin
                    random_query();
                end
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
